// ===== rtl/core/rvdec_pkg.sv =====
package rvdec_pkg;

    // Major opcodes (bits 6:0)
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_OP_32    = 7'h3B;
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_JAL      = 7'h6F;
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;

    localparam logic [6:0] FUNCT7_ALT = 7'h20;

    // funct3, ALU group
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3, memory width
    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_D  = 3'd3;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;
    localparam logic [2:0] F3_WU = 3'd6;

    // funct3, branch condition
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0]  F3_PRIV    = 3'd0;
    localparam logic [2:0]  F3_JALR    = 3'd0;
    localparam logic [11:0] F12_ECALL  = 12'h000;
    localparam logic [11:0] F12_EBREAK = 12'h001;
    localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

    typedef enum logic [5:0] {
        OP_INVALID = 6'd0,
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
        OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW,
        OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI,
        OP_SRAI, OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW, OP_JALR,
        OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU,
        OP_SB, OP_SH, OP_SW, OP_SD,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
        OP_LUI, OP_AUIPC, OP_JAL, OP_ECALL, OP_EBREAK
    } op_t;

    typedef struct packed {
        logic uses_rd;
        logic uses_rs1;
        logic uses_rs2;
        logic uses_imm;
    } operand_use_t;

    typedef struct packed {
        logic [31:0] raw_word;
        logic [63:0] pc;
    } instr_t;

    typedef struct packed {
        op_t                op;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [31:0] imm;
        logic               uses_rd;
        logic               uses_rs1;
        logic               uses_rs2;
        logic               uses_imm;
        logic [63:0]        pc_out;
    } dec_t;

endpackage

// ===== rtl/core/rvdec_op_decode.sv =====
module rvdec_op_decode (
    input  logic [31:0]   raw_word,
    output rvdec_pkg::op_t op
);
    import rvdec_pkg::*;

    logic [6:0] opc;
    logic [2:0] f3;
    logic       alt;
    logic       sys_ok;

    assign opc    = raw_word[6:0];
    assign f3     = raw_word[14:12];
    assign alt    = (raw_word[31:25] == FUNCT7_ALT);
    assign sys_ok = (f3 == F3_PRIV) && (raw_word[11:7] == 5'd0) && (raw_word[19:15] == 5'd0);

    always_comb
    begin
        op = OP_INVALID;
        unique case (opc)
            OPC_OP:
            begin
                unique case (f3)
                    F3_ADD:  op = alt ? OP_SUB : OP_ADD;
                    F3_SLL:  op = OP_SLL;
                    F3_SLT:  op = OP_SLT;
                    F3_SLTU: op = OP_SLTU;
                    F3_XOR:  op = OP_XOR;
                    F3_SR:   op = alt ? OP_SRA : OP_SRL;
                    F3_OR:   op = OP_OR;
                    F3_AND:  op = OP_AND;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_OP_32:
            begin
                unique case (f3)
                    F3_ADD:  op = alt ? OP_SUBW : OP_ADDW;
                    F3_SLL:  op = OP_SLLW;
                    F3_SR:   op = alt ? OP_SRAW : OP_SRLW;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_OP_IMM:
            begin
                unique case (f3)
                    F3_ADD:  op = OP_ADDI;
                    F3_SLL:  op = OP_SLLI;
                    F3_SLT:  op = OP_SLTI;
                    F3_SLTU: op = OP_SLTIU;
                    F3_XOR:  op = OP_XORI;
                    F3_SR:   op = alt ? OP_SRAI : OP_SRLI;
                    F3_OR:   op = OP_ORI;
                    F3_AND:  op = OP_ANDI;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_OP_IMM32:
            begin
                unique case (f3)
                    F3_ADD:  op = OP_ADDIW;
                    F3_SLL:  op = OP_SLLIW;
                    F3_SR:   op = alt ? OP_SRAIW : OP_SRLIW;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_LOAD:
            begin
                unique case (f3)
                    F3_B:    op = OP_LB;
                    F3_H:    op = OP_LH;
                    F3_W:    op = OP_LW;
                    F3_D:    op = OP_LD;
                    F3_BU:   op = OP_LBU;
                    F3_HU:   op = OP_LHU;
                    F3_WU:   op = OP_LWU;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_STORE:
            begin
                unique case (f3)
                    F3_B:    op = OP_SB;
                    F3_H:    op = OP_SH;
                    F3_W:    op = OP_SW;
                    F3_D:    op = OP_SD;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_BRANCH:
            begin
                unique case (f3)
                    F3_BEQ:  op = OP_BEQ;
                    F3_BNE:  op = OP_BNE;
                    F3_BLT:  op = OP_BLT;
                    F3_BGE:  op = OP_BGE;
                    F3_BLTU: op = OP_BLTU;
                    F3_BGEU: op = OP_BGEU;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_JALR:  op = (f3 == F3_JALR) ? OP_JALR : OP_INVALID;
            OPC_JAL:   op = OP_JAL;
            OPC_LUI:   op = OP_LUI;
            OPC_AUIPC: op = OP_AUIPC;
            OPC_SYSTEM:
            begin
                // only the two bare privileged calls; CSR forms fall out as invalid
                priority if (sys_ok && raw_word[31:20] == F12_ECALL)
                    op = OP_ECALL;
                else if (sys_ok && raw_word[31:20] == F12_EBREAK)
                    op = OP_EBREAK;
                else
                    op = OP_INVALID;
            end
            default:   op = OP_INVALID;
        endcase
    end

endmodule

// ===== rtl/core/rvdec_imm_gen.sv =====
module rvdec_imm_gen (
    input  logic [31:0]             raw_word,
    input  rvdec_pkg::op_t          op,
    output logic signed [31:0]      imm,
    output rvdec_pkg::operand_use_t uses
);
    import rvdec_pkg::*;

    logic [31:0] w;
    logic        k_reg;
    logic        k_imm;
    logic        k_store;
    logic        k_br;
    logic        k_upper;
    logic        k_jump;

    assign w       = raw_word;
    assign k_reg   = (op >= OP_ADD)  && (op <= OP_SRAW);
    assign k_imm   = (op >= OP_ADDI) && (op <= OP_LWU);
    assign k_store = (op >= OP_SB)   && (op <= OP_SD);
    assign k_br    = (op >= OP_BEQ)  && (op <= OP_BGEU);
    assign k_upper = (op == OP_LUI)  || (op == OP_AUIPC);
    assign k_jump  = (op == OP_JAL);

    always_comb
    begin
        uses.uses_rd  = k_reg | k_imm | k_upper | k_jump;
        uses.uses_rs1 = k_reg | k_imm | k_store | k_br;
        uses.uses_rs2 = k_reg | k_store | k_br;
        uses.uses_imm = k_imm | k_store | k_br | k_upper | k_jump;
    end

    always_comb
    begin
        priority if (k_imm)
            imm = {{20{w[31]}}, w[31:20]};
        else if (k_store)
            imm = {{20{w[31]}}, w[31:25], w[11:7]};
        else if (k_br)
            imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        else if (k_upper)
            imm = w & UPPER_MASK;
        else if (k_jump)
            imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        else
            imm = '0;
    end

endmodule

// ===== rtl/core/rv64i_instruction_decoder.sv =====
// RV64I instruction decoder.
//
// Input channel: instr_valid / instr_stall / instr carry one beat per
// instruction: the 32-bit encoding and its 64-bit pc.
// Output channel: dec_valid / dec_stall / dec carry one decoded beat per
// instruction: operation index, rd/rs1/rs2, sign-extended immediate,
// operand-use flags and the pc passed through.
//
// A beat is taken at a clock edge where valid is high and stall is low.
// The beat lands in the input register at acceptance, is decoded by
// shallow muxing while it sits there, and the result register shows it
// once it moves on. Throughput is one beat per cycle when dec_stall is
// low, set by the two-stage register pipeline with no shared unit.
//
// If the receiver stalls, the result register holds its beat; the input
// register keeps filling until both stages are occupied, and only then is
// instr_stall raised. Reset (rst_n low, async) empties both stages; no
// clearing pass is needed.
module rv64i_instruction_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              instr_valid,
    output logic              instr_stall,
    input  rvdec_pkg::instr_t instr,
    output logic              dec_valid,
    input  logic              dec_stall,
    output rvdec_pkg::dec_t   dec
);
    import rvdec_pkg::*;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    instr_t       s1_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    dec_t         out_reg;
    dec_t         out_next;

    logic         s1_adv;
    logic         in_take;
    op_t          op;
    logic [31:0]  imm;
    operand_use_t uses;

    // stage 1 moves on when the result slot is free or is drained this cycle
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || !dec_stall);
    assign instr_stall = s1_valid_reg && !s1_adv;
    assign in_take     = instr_valid && !instr_stall;

    rvdec_op_decode u_op (
        .raw_word (s1_reg.raw_word),
        .op       (op)
    );

    rvdec_imm_gen u_imm (
        .raw_word (s1_reg.raw_word),
        .op       (op),
        .imm      (imm),
        .uses     (uses)
    );

    always_comb
    begin
        out_next.op       = op;
        out_next.rd       = s1_reg.raw_word[11:7];
        out_next.rs1      = s1_reg.raw_word[19:15];
        out_next.rs2      = s1_reg.raw_word[24:20];
        out_next.imm      = imm;
        out_next.uses_rd  = uses.uses_rd;
        out_next.uses_rs1 = uses.uses_rs1;
        out_next.uses_rs2 = uses.uses_rs2;
        out_next.uses_imm = uses.uses_imm;
        out_next.pc_out   = s1_reg.pc;
    end

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && dec_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_reg <= instr;
        if (s1_adv)
            out_reg <= out_next;
    end

    assign dec_valid = out_valid_reg;
    assign dec       = out_reg;

    a_imm_zero_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !dec.uses_imm) |-> (dec.imm == 32'sd0))
        else $error("immediate nonzero while unused");

    a_invalid_no_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && dec.op == OP_INVALID) |->
        !(dec.uses_rd || dec.uses_rs1 || dec.uses_rs2 || dec.uses_imm))
        else $error("invalid op flags an operand");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && s1_valid_reg) |-> s1_adv)
        else $error("input register overwritten while full");

    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> dec_valid)
        else $error("decoded beat lost at result register");

    a_pc_through: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (dec.pc_out == $past(s1_reg.pc)))
        else $error("pc not carried through");

endmodule
